@@ sv/tdcl_pkg.sv @@
// ----------------------------------------------------------------------------
// tdcl_pkg: shared types, curve tables and helpers
// Curve points for the discharge and charge limit curves, the per-stage
// bundles that travel through the lookup pipeline, and the segment search.
// ----------------------------------------------------------------------------
`default_nettype none

package tdcl_pkg;

    // Field and internal widths
    localparam int TEMP_W    = 15;           // signed temperature, 0.01 C
    localparam int DIS_W     = 15;           // discharge limit, centiamps
    localparam int CHG_W     = 12;           // charge limit, centiamps
    localparam int AMP_W     = 16;           // signed holder for curve currents
    localparam int TABLE_CAP = 32;
    localparam int SEG_W     = $clog2(TABLE_CAP);
    localparam int SLOPE_W   = 8;            // centiamps per 0.01 C, signed
    localparam int DT_W      = TEMP_W + 2;   // offset into a segment, signed
    localparam int PROD_W    = DT_W + SLOPE_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int LANES     = 2;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 32;

    // Lane codes
    localparam logic LANE_DIS = 1'b0;
    localparam logic LANE_CHG = 1'b1;

    // Curve point counts, held to the legal range
    localparam int DISCHARGE_POINTS = 17;
    localparam int CHARGE_POINTS    = 13;
    localparam int DIS_N = (DISCHARGE_POINTS < 2) ? 2 :
                           (DISCHARGE_POINTS > TABLE_CAP) ? TABLE_CAP : DISCHARGE_POINTS;
    localparam int CHG_N = (CHARGE_POINTS < 2) ? 2 :
                           (CHARGE_POINTS > TABLE_CAP) ? TABLE_CAP : CHARGE_POINTS;

    // Discharge curve: temperature in 0.01 C, current in centiamps
    localparam int DIS_TEMP [TABLE_CAP] = '{
        -2000, -1000, 0, 1000, 1500, 2500, 3500, 4500,
        5000, 5500, 6000, 6500, 7000, 7500, 8000, 9000,
        10000, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };
    localparam int DIS_AMPS [TABLE_CAP] = '{
        0, 4000, 10000, 16000, 18000, 18000, 18000, 18000,
        18000, 18000, 18000, 18000, 18000, 18000, 18000, 10000,
        0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };
    // Rise over width of each discharge segment; every rise is a whole
    // multiple of its width, so the interpolation needs no division
    localparam int DIS_SLOPE [TABLE_CAP] = '{
        4, 6, 6, 4, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, -8, -10,
        0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    // Charge curve
    localparam int CHG_TEMP [TABLE_CAP] = '{
        -2000, -1000, 0, 500, 1000, 1500, 2000, 2500,
        3500, 4000, 4500, 5000, 6000, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };
    localparam int CHG_AMPS [TABLE_CAP] = '{
        0, 0, 0, 500, 1500, 2500, 3000, 3000,
        3000, 2000, 500, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };
    localparam int CHG_SLOPE [TABLE_CAP] = '{
        0, 0, 1, 2, 2, 1, 0, 0,
        -2, -3, -1, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    // Stage 1 result for one lane: either a direct current or a segment
    typedef struct packed {
        logic                      direct;
        logic signed [AMP_W-1:0]   base;
        logic [SEG_W-1:0]          seg;
        logic signed [TEMP_W-1:0]  temp;
    } tdcl_find_t;

    typedef struct packed {
        logic                      valid;
        tdcl_find_t [LANES-1:0]    lane;
    } tdcl_s1_t;

    // Stage 2 result for one lane: left current, offset and slope
    typedef struct packed {
        logic signed [AMP_W-1:0]   y0;
        logic signed [DT_W-1:0]    dt;
        logic signed [SLOPE_W-1:0] slope;
    } tdcl_offs_t;

    // Stage 3 result for one lane: left current and scaled offset
    typedef struct packed {
        logic signed [AMP_W-1:0]   y0;
        logic signed [PROD_W-1:0]  prod;
    } tdcl_prod_t;

    typedef struct packed {
        logic                      valid;
        tdcl_prod_t [LANES-1:0]    lane;
    } tdcl_s3_t;

    // Table reads
    function automatic int curve_n(input logic lane);
        curve_n = (lane == LANE_CHG) ? CHG_N : DIS_N;
    endfunction

    function automatic logic signed [TEMP_W:0] curve_temp(input logic lane,
                                                          input logic [SEG_W-1:0] idx);
        curve_temp = (lane == LANE_CHG) ? (TEMP_W+1)'(CHG_TEMP[idx])
                                        : (TEMP_W+1)'(DIS_TEMP[idx]);
    endfunction

    function automatic logic signed [AMP_W-1:0] curve_amps(input logic lane,
                                                           input logic [SEG_W-1:0] idx);
        curve_amps = (lane == LANE_CHG) ? AMP_W'(CHG_AMPS[idx]) : AMP_W'(DIS_AMPS[idx]);
    endfunction

    function automatic logic signed [SLOPE_W-1:0] curve_slope(input logic lane,
                                                              input logic [SEG_W-1:0] idx);
        curve_slope = (lane == LANE_CHG) ? SLOPE_W'(CHG_SLOPE[idx])
                                         : SLOPE_W'(DIS_SLOPE[idx]);
    endfunction

    // Clamp at both curve ends, else find the first segment whose right
    // point lies above the temperature
    function automatic tdcl_find_t seg_find(input logic lane,
                                            input logic signed [TEMP_W-1:0] t);
        tdcl_find_t       r;
        logic             found;
        logic [SEG_W-1:0] seg;
        logic [SEG_W-1:0] last;
        r      = '0;
        r.temp = t;
        found  = 1'b0;
        seg    = '0;
        last   = SEG_W'(curve_n(lane) - 1);
        for (int i = TABLE_CAP - 2; i >= 0; i--)
        begin
            if ((i < curve_n(lane) - 1) && (t < curve_temp(lane, SEG_W'(i + 1))))
            begin
                seg   = SEG_W'(i);
                found = 1'b1;
            end
        end
        priority if (t <= curve_temp(lane, '0))
        begin
            r.direct = 1'b1;
            r.base   = curve_amps(lane, '0);
        end
        else if (t >= curve_temp(lane, last))
        begin
            r.direct = 1'b1;
            r.base   = curve_amps(lane, last);
        end
        else if (found)
        begin
            r.direct = 1'b0;
            r.seg    = seg;
            r.base   = curve_amps(lane, seg);
        end
        else
        begin
            r.direct = 1'b1;
            r.base   = '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/tdcl_seg_find.sv @@
// ----------------------------------------------------------------------------
// tdcl_seg_find: segment search stage
// Compares each temperature against its curve points and registers either a
// clamped end current or the segment index with its left current.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcl_seg_find
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic signed [tdcl_pkg::TEMP_W-1:0] hot_temp,
    input  wire logic signed [tdcl_pkg::TEMP_W-1:0] cold_temp,
    output logic                                   in_ready,
    output tdcl_pkg::tdcl_s1_t                     s1,
    input  wire logic                              s1_ready
);

    logic                valid_reg;
    logic                valid_next;
    tdcl_pkg::tdcl_find_t [tdcl_pkg::LANES-1:0] lane_reg;
    tdcl_pkg::tdcl_find_t [tdcl_pkg::LANES-1:0] lane_next;

    // Take a new item whenever this stage is empty or drains this cycle
    assign in_ready = !valid_reg || s1_ready;

    // Search both curves side by side
    always_comb
    begin
        valid_next = valid_reg;
        lane_next  = lane_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            lane_next[tdcl_pkg::LANE_DIS] = tdcl_pkg::seg_find(tdcl_pkg::LANE_DIS, hot_temp);
            lane_next[tdcl_pkg::LANE_CHG] = tdcl_pkg::seg_find(tdcl_pkg::LANE_CHG, cold_temp);
        end
    end

    // Hold the valid bit under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign s1.valid = valid_reg;
    assign s1.lane  = lane_reg;

endmodule

`default_nettype wire

@@ sv/tdcl_interp.sv @@
// ----------------------------------------------------------------------------
// tdcl_interp: offset and slope multiply stages
// Stage 2 forms the offset into the segment and fetches its slope; stage 3
// multiplies the two. A clamped lane carries a zero offset.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcl_interp
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tdcl_pkg::tdcl_s1_t s1,
    output logic                    s1_ready,
    output tdcl_pkg::tdcl_s3_t      s3,
    input  wire logic               s3_ready
);

    logic s2_valid_reg;
    logic s2_valid_next;
    logic s3_valid_reg;
    logic s3_valid_next;
    logic s2_ready;
    logic s3_ready_int;
    tdcl_pkg::tdcl_offs_t [tdcl_pkg::LANES-1:0] s2_reg;
    tdcl_pkg::tdcl_offs_t [tdcl_pkg::LANES-1:0] s2_next;
    tdcl_pkg::tdcl_prod_t [tdcl_pkg::LANES-1:0] s3_reg;
    tdcl_pkg::tdcl_prod_t [tdcl_pkg::LANES-1:0] s3_next;

    // Each stage advances when empty or when the next one takes its item
    assign s3_ready_int = !s3_valid_reg || s3_ready;
    assign s2_ready     = !s2_valid_reg || s3_ready_int;
    assign s1_ready     = s2_ready;

    // Stage 2: offset from the left point, slope of the segment
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_next       = s2_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1.valid;
            for (int l = 0; l < tdcl_pkg::LANES; l++)
            begin
                s2_next[l].y0 = s1.lane[l].base;
                if (s1.lane[l].direct)
                begin
                    s2_next[l].dt    = '0;
                    s2_next[l].slope = '0;
                end
                else
                begin
                    s2_next[l].dt = tdcl_pkg::DT_W'(s1.lane[l].temp)
                        - tdcl_pkg::DT_W'(tdcl_pkg::curve_temp(1'(l), s1.lane[l].seg));
                    s2_next[l].slope = tdcl_pkg::curve_slope(1'(l), s1.lane[l].seg);
                end
            end
        end
    end

    // Stage 3: scale the offset by the slope
    always_comb
    begin
        s3_valid_next = s3_valid_reg;
        s3_next       = s3_reg;
        if (s3_ready_int)
        begin
            s3_valid_next = s2_valid_reg;
            for (int l = 0; l < tdcl_pkg::LANES; l++)
            begin
                s3_next[l].y0   = s2_reg[l].y0;
                s3_next[l].prod = tdcl_pkg::PROD_W'(s2_reg[l].dt)
                                * tdcl_pkg::PROD_W'(s2_reg[l].slope);
            end
        end
    end

    // Hold the valid bits under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
        s3_reg <= s3_next;
    end

    assign s3.valid = s3_valid_reg;
    assign s3.lane  = s3_reg;

endmodule

`default_nettype wire

@@ sv/tdcl_out.sv @@
// ----------------------------------------------------------------------------
// tdcl_out: final sum and output register
// Adds the scaled offset to the left current, clears negative results and
// holds the finished item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcl_out
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tdcl_pkg::tdcl_s3_t               s3,
    output logic                                  s3_ready,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [tdcl_pkg::DIS_W-1:0]            discharge_limit,
    output logic [tdcl_pkg::CHG_W-1:0]            charge_limit
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [tdcl_pkg::DIS_W-1:0]       dis_reg;
    logic [tdcl_pkg::DIS_W-1:0]       dis_next;
    logic [tdcl_pkg::CHG_W-1:0]       chg_reg;
    logic [tdcl_pkg::CHG_W-1:0]       chg_next;
    logic signed [tdcl_pkg::SUM_W-1:0] sum [tdcl_pkg::LANES];
    logic signed [tdcl_pkg::SUM_W-1:0] pos [tdcl_pkg::LANES];

    assign s3_ready = !valid_reg || out_ready;

    // Add and clear anything below zero
    always_comb
    begin
        for (int l = 0; l < tdcl_pkg::LANES; l++)
        begin
            sum[l] = tdcl_pkg::SUM_W'(s3.lane[l].y0) + tdcl_pkg::SUM_W'(s3.lane[l].prod);
            pos[l] = (sum[l] < 0) ? '0 : sum[l];
        end
    end

    // Load the output register when it is free
    always_comb
    begin
        valid_next = valid_reg;
        dis_next   = dis_reg;
        chg_next   = chg_reg;
        if (s3_ready)
        begin
            valid_next = s3.valid;
            dis_next   = pos[tdcl_pkg::LANE_DIS][tdcl_pkg::DIS_W-1:0];
            chg_next   = pos[tdcl_pkg::LANE_CHG][tdcl_pkg::CHG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        dis_reg <= dis_next;
        chg_reg <= chg_next;
    end

    assign out_valid       = valid_reg;
    assign discharge_limit = dis_reg;
    assign charge_limit    = chg_reg;

endmodule

`default_nettype wire

@@ sv/temp_derated_current_limits_core.sv @@
// ----------------------------------------------------------------------------
// temp_derated_current_limits_core: temperature-derated current limits
// Looks up a discharge limit from the hottest cell temperature and a charge
// limit from the coldest, each on a fixed piecewise-linear curve.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one item per sample, hot and cold temperature in
//   tdata, the drive-mode flag in tuser. Items with the flag low are accepted
//   and dropped without a result.
//   Output stream (m_axis_*): one item per drive-mode sample carrying the
//   discharge and charge limits in centiamps, in input order.
//   Pipeline: each item passes four register stages (segment search, offset,
//   slope multiply, sum into the output register), the first loaded at the
//   accept edge.
//   Throughput: one item per cycle while m_axis_tready is high; each stage is
//   registered and advances on its own valid/ready; any bubble fills at once.
//   Stall: while m_axis_tready is low the pipeline keeps filling its empty
//   stages; s_axis_tready drops only when all four stages hold an item.
//   Nothing is lost or repeated across a stall.
//   Reset: rst_n clears all valid bits; the payload registers are not reset
//   and the block is ready for input in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module temp_derated_current_limits_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [14:0] hot_temp, [29:15] cold_temp, [31:30] zero
    input  wire logic [tdcl_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    // [0] drive_mode
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [14:0] discharge_limit, [26:15] charge_limit, [31:27] zero
    output logic [tdcl_pkg::TDATA_OUT_W-1:0]         m_axis_tdata
);

    localparam int HOT_LO  = 0;
    localparam int COLD_LO = tdcl_pkg::TEMP_W;
    localparam int CHG_LO  = tdcl_pkg::DIS_W;
    localparam int PAD_W   = tdcl_pkg::TDATA_OUT_W - tdcl_pkg::DIS_W - tdcl_pkg::CHG_W;

    logic signed [tdcl_pkg::TEMP_W-1:0] hot_temp;
    logic signed [tdcl_pkg::TEMP_W-1:0] cold_temp;
    logic                               s1_ready;
    logic                               s3_ready;
    tdcl_pkg::tdcl_s1_t                 s1;
    tdcl_pkg::tdcl_s3_t                 s3;
    logic [tdcl_pkg::DIS_W-1:0]         discharge_limit;
    logic [tdcl_pkg::CHG_W-1:0]         charge_limit;

    // Unpack the input item
    assign hot_temp  = s_axis_tdata[HOT_LO +: tdcl_pkg::TEMP_W];
    assign cold_temp = s_axis_tdata[COLD_LO +: tdcl_pkg::TEMP_W];

    // Drop items outside drive mode at the first stage
    tdcl_seg_find u_find
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid && s_axis_tuser),
        .hot_temp  (hot_temp),
        .cold_temp (cold_temp),
        .in_ready  (s_axis_tready),
        .s1        (s1),
        .s1_ready  (s1_ready)
    );

    tdcl_interp u_interp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1       (s1),
        .s1_ready (s1_ready),
        .s3       (s3),
        .s3_ready (s3_ready)
    );

    tdcl_out u_out
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s3              (s3),
        .s3_ready        (s3_ready),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .discharge_limit (discharge_limit),
        .charge_limit    (charge_limit)
    );

    // Pack the result item
    assign m_axis_tdata[0 +: tdcl_pkg::DIS_W]      = discharge_limit;
    assign m_axis_tdata[CHG_LO +: tdcl_pkg::CHG_W] = charge_limit;
    assign m_axis_tdata[tdcl_pkg::TDATA_OUT_W-1 -: PAD_W] = '0;

endmodule

`default_nettype wire

@@ sv/tdcl_checker.sv @@
// ----------------------------------------------------------------------------
// tdcl_checker: port-level checks for the current limit block
// Watches the stream ports of the top level; attached by bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcl_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // Limits stay within the curve ranges
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14:0] <= 15'd18000)
                       && (m_axis_tdata[26:15] <= 12'd3000))
        else $error("limit outside curve range");

    // Padding bits stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:27] == 5'd0))
        else $error("padding bits set");

    // With no result waiting, every stage can move, so input is open
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

endmodule

bind temp_derated_current_limits_core tdcl_checker u_tdcl_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
